>>> hdl/srf_pkg.sv
// Shared types and constants of the substring removal filter.
package srf_pkg;

  localparam int WIN_MAX = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

  typedef struct packed {
    logic [WIN_MAX-1:0][7:0] bytes;
    logic [3:0]              emit;
    logic [2:0]              top;
    logic                    last;
  } cmd_t;

endpackage

>>> hdl/srf_if.sv
// Stream interfaces for text bytes in and filtered results out.
interface srf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface srf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        has_char;
  logic        out_last;
  logic [15:0] kept_length;

  modport source (output valid, output out_char, output has_char, output out_last,
                  output kept_length, input ready);
  modport sink (input valid, input out_char, input has_char, input out_last,
                input kept_length, output ready);
endinterface

>>> hdl/srf_front.sv
// Front end: window of pending bytes, pattern compare and emit command build.
module srf_front #(
  parameter int MAX_PATTERN = 8
) (
  input  logic            clk,
  input  logic            rst,
  srf_in_if.sink          text_in,
  input  logic [63:0]     pattern_bytes,
  input  logic [3:0]      pattern_length,
  input  logic            q_full,
  output logic            q_push,
  output srf_pkg::cmd_t   q_cmd
);
  import srf_pkg::*;

  localparam int D = MAX_PATTERN;

  logic [7:0] hist [D];
  logic [3:0] count;

  logic [7:0] hist_new [D];
  logic [7:0] hist_next [D];
  logic [3:0] len;
  logic [3:0] n;
  logic [3:0] r;
  logic [3:0] e;
  logic       matched;
  logic       accept;

  always_comb begin
    len = pattern_length;
    if (len == 4'd0) begin
      len = 4'd1;
    end else if (len > 4'(D)) begin
      len = 4'(D);
    end

    hist_new[0] = text_in.in_char;
    for (int j = 1; j < D; j++) begin
      hist_new[j] = hist[j-1];
    end

    n = count + 4'd1;
    matched = (n >= len);
    for (int j = 0; j < D; j++) begin
      for (int k = 0; k < WIN_MAX; k++) begin
        if ((4'(j) < len) && (4'(k) == len - 4'(j) - 4'd1) &&
            (hist_new[j] != pattern_bytes[k*8 +: 8])) begin
          matched = 1'b0;
        end
      end
    end

    r = matched ? n - len : n;
    if (text_in.in_last) begin
      e = r;
    end else if (r >= len) begin
      e = r - len + 4'd1;
    end else begin
      e = 4'd0;
    end

    for (int j = 0; j < D; j++) begin
      hist_next[j] = hist_new[j];
      if (matched) begin
        for (int k = 0; k < D; k++) begin
          if (4'(k) == 4'(j) + len) begin
            hist_next[j] = hist_new[k];
          end
        end
      end
    end

    q_cmd.bytes = '0;
    for (int j = 0; j < D; j++) begin
      q_cmd.bytes[j] = hist_new[j];
    end
    q_cmd.emit = e;
    q_cmd.top  = 3'(n - 4'd1);
    q_cmd.last = text_in.in_last;
  end

  assign text_in.ready = !q_full;
  assign accept        = text_in.valid && text_in.ready;
  assign q_push        = accept && (text_in.in_last || (e != 4'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 4'd0;
    end else if (accept) begin
      count <= text_in.in_last ? 4'd0 : r - e;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist <= hist_next;
    end
  end

endmodule

>>> hdl/srf_queue.sv
// Command queue between front end and back end.
module srf_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  srf_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output srf_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import srf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;

  assign full  = (fill == FW'(DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

>>> hdl/srf_back.sv
// Back end: expand commands into results, count kept bytes, output register.
module srf_back (
  input  logic          clk,
  input  logic          rst,
  input  srf_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          q_pop,
  srf_out_if.source     text_out
);
  import srf_pkg::*;

  logic [3:0]  idx;
  logic [15:0] kept;
  logic        res_valid;
  logic [7:0]  res_char;
  logic        res_has;
  logic        res_end;
  logic [15:0] res_kept;

  logic [3:0]  n_res;
  logic [3:0]  sel;
  logic [7:0]  cur_char;
  logic        cur_has;
  logic        cur_last;
  logic        is_end;
  logic        load;
  logic [15:0] kept_inc;

  always_comb begin
    n_res   = (head.emit == 4'd0) ? 4'd1 : head.emit;
    is_end  = (idx == n_res - 4'd1);
    sel     = {1'b0, head.top} - idx;
    cur_char = 8'd0;
    for (int j = 0; j < WIN_MAX; j++) begin
      if (4'(j) == sel) begin
        cur_char = head.bytes[j];
      end
    end
    cur_has  = (head.emit != 4'd0);
    cur_last = head.last && is_end;
    kept_inc = (kept == 16'hFFFF) ? kept : kept + 16'd1;
  end

  assign load  = !q_empty && (!res_valid || text_out.ready);
  assign q_pop = load && is_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 4'd0;
      kept      <= 16'd0;
    end else if (load) begin
      res_valid <= 1'b1;
      idx       <= is_end ? 4'd0 : idx + 4'd1;
      if (cur_last) begin
        kept <= 16'd0;
      end else if (cur_has) begin
        kept <= kept_inc;
      end
    end else if (text_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_char <= cur_has ? cur_char : 8'd0;
      res_has  <= cur_has;
      res_end  <= cur_last;
      res_kept <= cur_last ? (cur_has ? kept_inc : kept) : 16'd0;
    end
  end

  assign text_out.valid       = res_valid;
  assign text_out.out_char    = res_char;
  assign text_out.has_char    = res_has;
  assign text_out.out_last    = res_end;
  assign text_out.kept_length = res_kept;

endmodule

>>> hdl/substring_removal_filter_core.sv
// Top level of the substring removal filter.
// Deletes every leftmost, non-overlapping occurrence of a 1 to 8 byte pattern
// from a byte stream. text_in carries one byte per transfer with in_last on
// the final byte of a text; text_out carries the kept bytes in order, and the
// final result of a text has out_last set and kept_length holding the number
// of kept bytes (saturating at 65535). A text that keeps nothing ends with a
// bare marker (has_char 0). Configure through cfg_we/cfg_index/cfg_data
// while no text is in flight: index 0 is the pattern, index 1 its length.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver keeps up; a byte that releases k results yields k output
// transfers, and the command queue lets the input keep running meanwhile.
// The command is written to the queue at the input transfer, and the output
// register loads it from the queue head once the output register is free.
// Reset empties the window and the queue and clears the counter and the output.
// When the receiver stalls the output holds, the queue fills, and text_in
// ready drops once QUEUE_DEPTH commands wait.
module substring_removal_filter_core #(
  parameter int MAX_PATTERN = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  srf_in_if.sink                           text_in,
  srf_out_if.source                        text_out,
  input  logic                             cfg_we,
  input  logic [srf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                      cfg_data
);
  import srf_pkg::*;

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  cmd_t        q_wr;
  cmd_t        q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= 64'd0;
      pattern_length <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  srf_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
    .clk            (clk),
    .rst            (rst),
    .text_in        (text_in),
    .pattern_bytes  (pattern_bytes),
    .pattern_length (pattern_length),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_wr)
  );

  srf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (q_wr),
    .pop    (q_pop),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  srf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .text_out (text_out)
  );

endmodule

>>> hdl/srf_checker.sv
// Port-level checks of the substring removal filter output.
module srf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_char,
  input logic        has_char,
  input logic        out_last,
  input logic [15:0] kept_length
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled result changed");

  a_kept_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> kept_length == 16'd0)
    else $error("kept length on non-final result");

  a_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> out_last && out_char == 8'd0)
    else $error("bad end marker");

  a_kept_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last && has_char |-> kept_length != 16'd0)
    else $error("final byte not counted");

endmodule

bind substring_removal_filter_core srf_checker u_srf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (text_out.valid),
  .out_ready   (text_out.ready),
  .out_char    (text_out.out_char),
  .has_char    (text_out.has_char),
  .out_last    (text_out.out_last),
  .kept_length (text_out.kept_length)
);
